>>> rtl/latched_chr_bank_mapper_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the latched CHR bank mapper
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef LATCHED_CHR_BANK_MAPPER_TOP_MACROS_SVH
`define LATCHED_CHR_BANK_MAPPER_TOP_MACROS_SVH

// same-cycle implication
`define LCBM_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LCBM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lcbm_pkg.sv
// ----------------------------------------------------------------------------
// lcbm_pkg
// Types, codes and helpers shared by the latched CHR bank mapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lcbm_pkg;

  typedef enum logic [1:0] {
    ACT_CPU_WRITE = 2'd0,
    ACT_CPU_READ  = 2'd1,
    ACT_PPU_FETCH = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    MIR_THREE_ONE = 2'd0,
    MIR_HORIZ     = 2'd1,
    MIR_VERT      = 2'd2,
    MIR_SINGLE    = 2'd3
  } mirror_e;

  localparam int unsigned PrgRegs = 3;
  localparam int unsigned ChrRegs = 4;

  localparam logic [7:0] FixedBank   = 8'hFF;
  localparam logic [7:0] LatchSetTag = 8'hFD;
  localparam logic [7:0] LatchClrTag = 8'hFE;
  localparam logic [1:0] PrgSlotFix  = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] address;
    logic [7:0]  data;
  } req_t;

  typedef struct packed {
    logic [7:0] bank;
    logic       page;
    logic [1:0] mirror_mode;
    logic       mapped;
  } rsp_t;

  function automatic logic nt_page(input logic [1:0] mode, input logic [1:0] quad);
    logic pg;
    unique case (mode)
      MIR_THREE_ONE: pg = (quad == 2'd3);
      MIR_HORIZ:     pg = quad[1];
      MIR_VERT:      pg = quad[0];
      default:       pg = 1'b1;
    endcase
    return pg;
  endfunction

endpackage

>>> rtl/lcbm_if.sv
// ----------------------------------------------------------------------------
// lcbm_req_if / lcbm_rsp_if
// Valid/ready channels carrying mapper requests and responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lcbm_req_if
  import lcbm_pkg::*;
();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface lcbm_rsp_if
  import lcbm_pkg::*;
();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/latched_chr_bank_mapper_top.sv
// ----------------------------------------------------------------------------
// latched_chr_bank_mapper_top
// Bank mapper with fetch-triggered CHR latches: input register, translation
// against the bank state, result register.
//
//   channel   dir   modport  payload
//   req_i     in    sink     action, address, data
//   rsp_o     out   source   bank, page, mirror_mode, mapped
//
// One request per cycle sustained while rsp_o accepts; the response passes
// through the input register, then the result register, before it is valid.
// State updates as the request moves into the result register.
// Reset clears all bank registers and both latches; no clearing pass.
// A stalled response holds; one more request waits in the input register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module latched_chr_bank_mapper_top
  import lcbm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  lcbm_req_if.sink   req_i,
  lcbm_rsp_if.source rsp_o
);

  logic s1_valid_q;
  req_t s1_req_q;
  logic out_valid_q;
  rsp_t out_rsp_q;
  rsp_t core_rsp;
  logic s1_adv;
  logic in_fire;

  assign s1_adv    = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign in_fire   = req_i.valid && req_i.ready;

  lcbm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s1_adv),
    .req_i  (s1_req_q),
    .rsp_o  (core_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_req_q <= req_i.payload;
    end
    if (s1_adv) begin
      out_rsp_q <= core_rsp;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_rsp_q;

endmodule

>>> rtl/lcbm_core.sv
// ----------------------------------------------------------------------------
// lcbm_core
// Bank registers, CHR latches and the combinational address translation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "latched_chr_bank_mapper_top_macros.svh"

module lcbm_core
  import lcbm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic fire_i,
  input  req_t req_i,
  output rsp_t rsp_o
);

  logic [7:0] prg_q [PrgRegs];
  logic [7:0] chr_q [ChrRegs];
  logic [1:0] latch_q;

  logic [1:0]  mode;
  logic [13:0] pa;
  logic        half;
  logic        latch_hit;

  assign pa        = req_i.address[13:0];
  assign half      = pa[12];
  assign mode      = chr_q[{1'b0, latch_q[0]}][7:6];
  assign latch_hit = (pa[11:4] == LatchSetTag) || (pa[11:4] == LatchClrTag);

  always_comb begin
    rsp_o             = '0;
    rsp_o.mirror_mode = mode;
    unique case (req_i.action)
      ACT_CPU_READ: begin
        if (req_i.address[15:13] == 3'b111) begin
          rsp_o.bank   = FixedBank;
          rsp_o.mapped = 1'b1;
        end else if (req_i.address[15]) begin
          rsp_o.bank   = prg_q[req_i.address[14:13]];
          rsp_o.mapped = 1'b1;
        end
      end
      ACT_PPU_FETCH: begin
        if (!pa[13]) begin
          rsp_o.bank   = chr_q[{half, latch_q[half]}];
          rsp_o.mapped = 1'b1;
        end else if (!pa[12]) begin
          rsp_o.page   = nt_page(mode, pa[11:10]);
          rsp_o.mapped = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PrgRegs; i++) prg_q[i] <= '0;
      for (int i = 0; i < ChrRegs; i++) chr_q[i] <= '0;
      latch_q <= '0;
    end else if (fire_i) begin
      if (req_i.action == ACT_CPU_WRITE) begin
        if (req_i.address[15:13] == 3'b111) begin
          chr_q[req_i.address[11:10]] <= req_i.data;
        end else if (req_i.address[15] && req_i.address[14:13] != PrgSlotFix) begin
          prg_q[req_i.address[14:13]] <= req_i.data;
        end
      end else if (req_i.action == ACT_PPU_FETCH && !pa[13] && latch_hit) begin
        latch_q[half] <= !pa[5];
      end
    end
  end

  `LCBM_ASSERT_NEXT(a_chr_write_lands,
    fire_i && req_i.action == ACT_CPU_WRITE && req_i.address[15:13] == 3'b111,
    chr_q[$past(req_i.address[11:10])] == $past(req_i.data),
    "CHR register write lost")
  `LCBM_ASSERT_NEXT(a_latch_set,
    fire_i && req_i.action == ACT_PPU_FETCH && !pa[13] && pa[11:4] == LatchSetTag,
    latch_q[$past(half)] == 1'b1,
    "latch not set by FD fetch")
  `LCBM_ASSERT_NEXT(a_latch_idle, !fire_i, $stable(latch_q),
    "latch moved without a request")

endmodule
